### hdl/dhsm_pkg.sv
// Package for the dense handle slot map: sizes, request and status codes,
// beat structs and the struct types that link the table memories to the core.
// No dependencies.
package dhsm_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int GRP         = 8;
	localparam int NGRP        = (MAX_ENTRIES + GRP - 1) / GRP;

	localparam logic [2:0] REQ_MAKE       = 3'd0;
	localparam logic [2:0] REQ_DESTROY    = 3'd1;
	localparam logic [2:0] REQ_LOOKUP     = 3'd2;
	localparam logic [2:0] REQ_SET_ACTIVE = 3'd3;
	localparam logic [2:0] REQ_CLR_ACTIVE = 3'd4;
	localparam logic [2:0] REQ_CLR_ALL    = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DEAD = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [5:0] handle;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] handle_out;
		logic [5:0] dense_index;
		logic       handle_live;
		logic       move_valid;
		logic [5:0] move_from;
		logic [5:0] move_to;
		logic       active_live;
		logic [5:0] active_out;
		logic [6:0] live_count;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] sh_addr;
		logic [IDX_W-1:0] hs_addr;
	} tbl_rd_t;

	typedef struct packed {
		logic             sh_we;
		logic [IDX_W-1:0] sh_addr;
		logic [IDX_W-1:0] sh_data;
		logic             hs_we;
		logic [IDX_W-1:0] hs_addr;
		logic [IDX_W-1:0] hs_data;
	} tbl_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] sh_data;
		logic [IDX_W-1:0] hs_data;
	} tbl_rdata_t;

endpackage

### hdl/dhsm_tables.sv
// Handle-to-slot and slot-to-handle memories, one write and one registered
// read port each. Depends on dhsm_pkg.
module dhsm_tables (
	input  logic                clk,
	input  dhsm_pkg::tbl_rd_t   rd,
	input  dhsm_pkg::tbl_wr_t   wr,
	output dhsm_pkg::tbl_rdata_t rdata
);

	logic [dhsm_pkg::IDX_W-1:0] slot_of_handle [dhsm_pkg::MAX_ENTRIES];
	logic [dhsm_pkg::IDX_W-1:0] handle_of_slot [dhsm_pkg::MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.sh_we) begin
			slot_of_handle[wr.sh_addr] <= wr.sh_data;
		end
		if (wr.hs_we) begin
			handle_of_slot[wr.hs_addr] <= wr.hs_data;
		end
		if (rd.rd_en) begin
			rdata.sh_data <= slot_of_handle[rd.sh_addr];
			rdata.hs_data <= handle_of_slot[rd.hs_addr];
		end
	end

endmodule

### hdl/dhsm_free_find.sv
// Lowest free handle search: registered per-group priority encode, then a
// small pick across groups. Depends on dhsm_pkg.
module dhsm_free_find (
	input  logic                             clk,
	input  logic [dhsm_pkg::MAX_ENTRIES-1:0] in_use,
	output logic [dhsm_pkg::IDX_W-1:0]       free_idx
);

	logic [dhsm_pkg::NGRP*dhsm_pkg::GRP-1:0] padded;
	logic [dhsm_pkg::NGRP-1:0]               grp_any;
	logic [2:0]                              grp_pos [dhsm_pkg::NGRP];
	logic [dhsm_pkg::NGRP-1:0]               grp_any_q;
	logic [2:0]                              grp_pos_q [dhsm_pkg::NGRP];

	// pad entries beyond the table as taken
	always_comb begin
		padded = '1;
		padded[dhsm_pkg::MAX_ENTRIES-1:0] = in_use;
	end

	always_comb begin
		for (int g = 0; g < dhsm_pkg::NGRP; g++) begin
			grp_any[g] = ~&padded[g*dhsm_pkg::GRP +: dhsm_pkg::GRP];
			grp_pos[g] = 3'd0;
			for (int j = dhsm_pkg::GRP - 1; j >= 0; j--) begin
				if (!padded[g*dhsm_pkg::GRP + j]) begin
					grp_pos[g] = 3'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_q <= grp_any;
		for (int g = 0; g < dhsm_pkg::NGRP; g++) begin
			grp_pos_q[g] <= grp_pos[g];
		end
	end

	always_comb begin
		free_idx = '0;
		for (int g = dhsm_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				free_idx = dhsm_pkg::IDX_W'(g * dhsm_pkg::GRP)
					+ dhsm_pkg::IDX_W'(grp_pos_q[g]);
			end
		end
	end

endmodule

### hdl/dense_handle_slot_map_core.sv
// Dense handle slot map core: handle table over a densely packed store.
// Timing: on acceptance the request and both table reads are registered and
// the core enters S_EXEC; there it registers the result beat and raises done.
// No new request is taken while a request executes (busy is high in S_EXEC);
// the receiver cannot stall the result.
// Reset: asynchronous, clears live bits, count and active handle at once.
// Depends on dhsm_pkg, dhsm_tables and dhsm_free_find.
module dense_handle_slot_map_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dhsm_pkg::req_t    req,
	output logic              done,
	output dhsm_pkg::result_t result
);

	localparam int IDX_W = dhsm_pkg::IDX_W;
	localparam int CNT_W = dhsm_pkg::CNT_W;
	localparam int MAXE  = dhsm_pkg::MAX_ENTRIES;

	dhsm_pkg::state_t     state_q, state_d;
	dhsm_pkg::req_t       req_q;
	dhsm_pkg::result_t    result_q, res;
	dhsm_pkg::tbl_rd_t    rd;
	dhsm_pkg::tbl_wr_t    wr;
	dhsm_pkg::tbl_rdata_t rdata;

	logic [MAXE-1:0]  in_use_q, in_use_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [5:0]       active_q, active_d;
	logic             aset_q, aset_d;
	logic             done_q;
	logic             accept;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] h, last, hole, moved;
	logic             was_live;

	dhsm_tables u_tables (
		.clk  (clk),
		.rd   (rd),
		.wr   (wr),
		.rdata(rdata)
	);

	dhsm_free_find u_free (
		.clk     (clk),
		.in_use  (in_use_q),
		.free_idx(free_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhsm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		accept  = 1'b0;
		unique case (state_q)
			dhsm_pkg::S_IDLE: begin
				accept = start;
				if (start) begin
					state_d = dhsm_pkg::S_EXEC;
				end
			end
			dhsm_pkg::S_EXEC: begin
				busy    = 1'b1;
				state_d = dhsm_pkg::S_IDLE;
			end
			default: begin
				state_d = dhsm_pkg::S_IDLE;
			end
		endcase
	end

	// issue both table reads on the accepting edge
	always_comb begin
		rd.rd_en   = accept;
		rd.sh_addr = IDX_W'(req.handle);
		rd.hs_addr = IDX_W'(count_q - CNT_W'(1));
	end

	always_comb begin
		h        = IDX_W'(req_q.handle);
		was_live = (32'(req_q.handle) < 32'(MAXE)) && in_use_q[h];
		last     = IDX_W'(count_q - CNT_W'(1));
		hole     = rdata.sh_data;
		moved    = rdata.hs_data;

		in_use_d = in_use_q;
		count_d  = count_q;
		active_d = active_q;
		aset_d   = aset_q;
		wr       = '0;

		res             = '0;
		res.status      = dhsm_pkg::STAT_OK;
		res.handle_out  = req_q.handle;
		res.handle_live = was_live;

		case (req_q.req_type)
			dhsm_pkg::REQ_MAKE: begin
				res.handle_live = 1'b0;
				res.handle_out  = 6'd0;
				if (count_q >= CNT_W'(MAXE)) begin
					res.status = dhsm_pkg::STAT_FULL;
				end else begin
					in_use_d[free_idx] = 1'b1;
					wr.sh_we           = 1'b1;
					wr.sh_addr         = free_idx;
					wr.sh_data         = IDX_W'(count_q);
					wr.hs_we           = 1'b1;
					wr.hs_addr         = IDX_W'(count_q);
					wr.hs_data         = free_idx;
					res.handle_out     = 6'(free_idx);
					res.dense_index    = 6'(count_q);
					res.handle_live    = 1'b1;
					count_d            = count_q + CNT_W'(1);
				end
			end
			dhsm_pkg::REQ_DESTROY: begin
				if (!was_live || count_q == '0) begin
					res.status = dhsm_pkg::STAT_DEAD;
				end else begin
					in_use_d[h]     = 1'b0;
					res.dense_index = 6'(hole);
					// fill the hole with the last dense entry
					if (hole != last) begin
						wr.sh_we       = 1'b1;
						wr.sh_addr     = moved;
						wr.sh_data     = hole;
						wr.hs_we       = 1'b1;
						wr.hs_addr     = hole;
						wr.hs_data     = moved;
						res.move_valid = 1'b1;
						res.move_from  = 6'(last);
						res.move_to    = 6'(hole);
					end
					count_d = count_q - CNT_W'(1);
				end
			end
			dhsm_pkg::REQ_LOOKUP: begin
				if (was_live) begin
					res.dense_index = 6'(hole);
				end else begin
					res.status = dhsm_pkg::STAT_DEAD;
				end
			end
			dhsm_pkg::REQ_SET_ACTIVE: begin
				if (was_live) begin
					res.dense_index = 6'(hole);
					active_d        = req_q.handle;
					aset_d          = 1'b1;
				end else begin
					res.status = dhsm_pkg::STAT_DEAD;
				end
			end
			dhsm_pkg::REQ_CLR_ACTIVE: begin
				active_d = 6'd0;
				aset_d   = 1'b0;
			end
			dhsm_pkg::REQ_CLR_ALL: begin
				in_use_d = '0;
				count_d  = '0;
				active_d = 6'd0;
				aset_d   = 1'b0;
			end
			default: begin
			end
		endcase

		if (state_q != dhsm_pkg::S_EXEC) begin
			wr = '0;
		end

		res.active_live = aset_d && (32'(active_d) < 32'(MAXE))
			&& in_use_d[IDX_W'(active_d)];
		res.active_out = active_d;
		res.live_count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			count_q  <= '0;
			active_q <= 6'd0;
			aset_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == dhsm_pkg::S_EXEC);
			if (state_q == dhsm_pkg::S_EXEC) begin
				in_use_q <= in_use_d;
				count_q  <= count_d;
				active_q <= active_d;
				aset_q   <= aset_d;
			end
		end
	end

	// payload registers: hold the request and the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == dhsm_pkg::S_EXEC) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
